// ===== rtl/core/timer_task_scheduler_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// timer task scheduler table - assertion macros
// concurrent assertion helpers for the asserting rtl file
// ----------------------------------------------------------------------------
`ifndef TIMER_TASK_SCHEDULER_TABLE_TOP_DEFINES_SVH
`define TIMER_TASK_SCHEDULER_TABLE_TOP_DEFINES_SVH

// generic form: explicit clock and active-low reset
`define TTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// house form: block clock and reset
`define TTS_ASSERT_CLK(label, prop, msg) \
  `TTS_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// types and constants of the timer task scheduler table
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int RESULT_LIMIT = 16;

  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int RES_IDX_W  = $clog2(RESULT_LIMIT);
  localparam int RES_CNT_W  = $clog2(RESULT_LIMIT + 1);

  localparam int KIND_W     = 2;
  localparam int ID_W       = 8;
  localparam int TIME_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int TASK_CNT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET      = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_UPDATED   = 3'd0,
    RES_ADDED     = 3'd1,
    RES_FULL      = 3'd2,
    RES_DELETED   = 3'd3,
    RES_NOT_FOUND = 3'd4,
    RES_TICKED    = 3'd5,
    RES_RUN       = 3'd6,
    RES_NONE      = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_TAIL_WR,
    ST_FIN,
    ST_RES,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic              ready;
  } entry_t;

endpackage

// ===== rtl/core/tts_if.sv =====
// ----------------------------------------------------------------------------
// tts_req_if / tts_rsp_if
// valid/ready channels for request and result items of the scheduler table
// ----------------------------------------------------------------------------
interface tts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  task_id;
  logic [15:0] start_delay;
  logic [15:0] repeat_period;

  modport source (output valid, kind, task_id, start_delay, repeat_period, input ready);
  modport sink   (input valid, kind, task_id, start_delay, repeat_period, output ready);
endinterface

interface tts_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] run_id;
  logic [4:0] task_count;
  logic       last;

  modport source (output valid, status, run_id, task_count, last, input ready);
  modport sink   (input valid, status, run_id, task_count, last, output ready);
endinterface

// ===== rtl/core/timer_task_scheduler_table_top.sv =====
// ----------------------------------------------------------------------------
// timer_task_scheduler_table_top
// cooperative timer task table with set, delete, tick and dispatch requests
// ----------------------------------------------------------------------------
// The block keeps up to TABLE_DEPTH tasks in a single-port-write, registered
// read table and serves one request item at a time; req_i.ready is high only
// while no request is in work. Every request but a set or delete with id zero
// walks the table entry by entry through one compare/decrement unit, with a
// read step and then an evaluate and write-back step per entry. A dispatch
// scan skips the entry moved into the slot of a one-shot task removed from
// the middle of the table; after the scan it gives one result when nothing
// is ready, else reads and delivers each buffered result item in turn.
// A stalled result side holds the block in its result states. Set with id
// zero returns nothing. Dispatch results all carry the task count after the
// whole pass, so they are buffered and delivered once the pass ends. No
// clearing pass is needed after reset: only entries below the task count are
// ever used. A finished result waits in the output register, and the next
// request is taken while it waits.
// ----------------------------------------------------------------------------
`include "timer_task_scheduler_table_top_defines.svh"

module timer_task_scheduler_table_top
  import tts_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  tts_req_if.sink       req_i,
  tts_rsp_if.source     rsp_o
);

  // sequencer state
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     idx_q, idx_d;       // scan position
  logic [CNT_W-1:0]     total_q, total_d;   // listed tasks
  logic [RES_CNT_W-1:0] n_q, n_d;           // buffered dispatch results
  logic [RES_CNT_W-1:0] k_q, k_d;           // dispatch result being delivered
  logic [CNT_W-1:0]     tail;

  // latched request item
  kind_e                op_kind_q;
  logic [ID_W-1:0]      op_id_q;
  logic [TIME_W-1:0]    op_dly_q;
  logic [TIME_W-1:0]    op_per_q;

  // pending single result
  status_e              res_status_q, res_status_d;
  logic [ID_W-1:0]      res_id_q, res_id_d;

  // task table, registered read
  entry_t               table_mem [TABLE_DEPTH];
  entry_t               rd_data_q;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;

  // dispatch id buffer, registered read
  logic [ID_W-1:0]      run_buf [RESULT_LIMIT];
  logic [ID_W-1:0]      run_buf_q;
  logic                 buf_we;

  // output register
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [ID_W-1:0]      out_id_q;
  logic [TASK_CNT_W-1:0] out_count_q;
  logic                 out_last_q;
  logic                 out_free;
  logic                 out_load;
  status_e              out_status_d;
  logic [ID_W-1:0]      out_id_d;
  logic                 out_last_d;
  logic [31:0]          total_ext;

  logic                 req_accept;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign tail        = CNT_W'(total_q - 1'b1);
  // reported count wraps modulo 32 for deep tables
  assign total_ext   = 32'(total_q);

  // --------------------------------------------------------------------------
  // sequencer: next state, table writes and result selection
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    total_d      = total_q;
    n_d          = n_q;
    k_d          = k_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    rd_addr      = idx_q[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = idx_q[IDX_W-1:0];
    mem_wdata    = rd_data_q;
    buf_we       = 1'b0;
    out_load     = 1'b0;
    out_status_d = res_status_q;
    out_id_d     = res_id_q;
    out_last_d   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (req_accept) begin
          idx_d = '0;
          n_d   = '0;
          unique case (kind_e'(req_i.kind))
            KIND_SET:    state_d = (req_i.task_id == '0) ? ST_IDLE : ST_RD;
            KIND_DELETE: state_d = (req_i.task_id == '0) ? ST_FIN : ST_RD;
            default:     state_d = ST_RD;
          endcase
        end
      end

      ST_RD: begin
        // end of table, or dispatch result buffer full
        if ((idx_q >= total_q) ||
            ((op_kind_q == KIND_DISPATCH) && (n_q == RES_CNT_W'(RESULT_LIMIT)))) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_EV;
        end
      end

      ST_EV: begin
        // fetch the tail entry in case this slot gets freed
        rd_addr = tail[IDX_W-1:0];
        state_d = ST_RD;
        idx_d   = CNT_W'(idx_q + 1'b1);
        unique case (op_kind_q)
          KIND_SET: begin
            if (rd_data_q.id == op_id_q) begin
              mem_we       = 1'b1;
              mem_wdata    = '{id: op_id_q, delay: op_dly_q, period: op_per_q, ready: 1'b0};
              res_status_d = RES_UPDATED;
              res_id_d     = op_id_q;
              state_d      = ST_RES;
            end
          end
          KIND_DELETE: begin
            if (rd_data_q.id == op_id_q) begin
              res_status_d = RES_DELETED;
              res_id_d     = op_id_q;
              idx_d        = idx_q;
              if (idx_q != tail) begin
                state_d = ST_TAIL_WR;
              end else begin
                total_d = tail;
                state_d = ST_RES;
              end
            end
          end
          KIND_TICK: begin
            mem_we = 1'b1;
            if (rd_data_q.delay == '0) begin
              mem_wdata.ready = 1'b1;
            end else begin
              mem_wdata.delay = TIME_W'(rd_data_q.delay - 1'b1);
            end
          end
          default: begin
            if (rd_data_q.ready) begin
              buf_we = 1'b1;
              n_d    = RES_CNT_W'(n_q + 1'b1);
              if (rd_data_q.period == '0) begin
                // one-shot: remove; the moved tail entry is skipped this pass
                if (idx_q != tail) begin
                  idx_d   = idx_q;
                  state_d = ST_TAIL_WR;
                end else begin
                  total_d = tail;
                end
              end else begin
                mem_we          = 1'b1;
                mem_wdata.ready = 1'b0;
                if (rd_data_q.delay == '0) begin
                  mem_wdata.delay = TIME_W'(rd_data_q.period - 1'b1);
                end
              end
            end
          end
        endcase
      end

      ST_TAIL_WR: begin
        // rd_data_q now holds the tail entry
        mem_we    = 1'b1;
        mem_wdata = rd_data_q;
        total_d   = tail;
        if (op_kind_q == KIND_DELETE) begin
          state_d = ST_RES;
        end else begin
          idx_d   = CNT_W'(idx_q + 1'b1);
          state_d = ST_RD;
        end
      end

      ST_FIN: begin
        state_d  = ST_RES;
        res_id_d = op_id_q;
        unique case (op_kind_q)
          KIND_SET: begin
            if (total_q < CNT_W'(TABLE_DEPTH)) begin
              mem_we       = 1'b1;
              mem_waddr    = total_q[IDX_W-1:0];
              mem_wdata    = '{id: op_id_q, delay: op_dly_q, period: op_per_q, ready: 1'b0};
              total_d      = CNT_W'(total_q + 1'b1);
              res_status_d = RES_ADDED;
            end else begin
              res_status_d = RES_FULL;
            end
          end
          KIND_DELETE: res_status_d = RES_NOT_FOUND;
          KIND_TICK: begin
            res_status_d = RES_TICKED;
            res_id_d     = '0;
          end
          default: begin
            res_status_d = RES_NONE;
            res_id_d     = '0;
            if (n_q != '0) begin
              k_d     = '0;
              state_d = ST_EMIT_RD;
            end
          end
        endcase
      end

      ST_RES: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end

      ST_EMIT_WR: begin
        out_status_d = RES_RUN;
        out_id_d     = run_buf_q;
        out_last_d   = (k_q == RES_CNT_W'(n_q - 1'b1));
        if (out_free) begin
          out_load = 1'b1;
          if (out_last_d) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = RES_CNT_W'(k_q + 1'b1);
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      total_q     <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      n_q     <= n_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request latch, pending result and output payload
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      op_kind_q <= kind_e'(req_i.kind);
      op_id_q   <= req_i.task_id;
      op_dly_q  <= req_i.start_delay;
      op_per_q  <= req_i.repeat_period;
    end
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_count_q  <= total_ext[TASK_CNT_W-1:0];
      out_last_q   <= out_last_d;
    end
  end

  // task table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= table_mem[rd_addr];
  end

  // dispatch id buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      run_buf[n_q[RES_IDX_W-1:0]] <= rd_data_q.id;
    end
    run_buf_q <= run_buf[k_q[RES_IDX_W-1:0]];
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.run_id     = out_id_q;
  assign rsp_o.task_count = out_count_q;
  assign rsp_o.last       = out_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `TTS_ASSERT_CLK(a_total_bound, total_q <= CNT_W'(TABLE_DEPTH), "task count beyond table depth")
  `TTS_ASSERT_CLK(a_res_bound, n_q <= RES_CNT_W'(RESULT_LIMIT), "dispatch buffer overrun")
  `TTS_ASSERT_CLK(a_ev_in_table, (state_q == ST_EV) |-> (idx_q < total_q), "evaluating an unlisted entry")
  `TTS_ASSERT_CLK(a_emit_in_buf, (state_q == ST_EMIT_WR) |-> (k_q < n_q), "delivering an unbuffered result")

endmodule
